FILE: design/rls_adaptive_filter_assert.svh
// Assertion macros shared by the checker files of the adaptive filter.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef RLS_ADAPTIVE_FILTER_ASSERT_SVH
`define RLS_ADAPTIVE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/rls_pkg.sv
// Shared types and constants of the adaptive filter: operation codes, controller
// states, command and status structs, register indexes and reset values.
// No dependencies.
package rls_pkg;

  // Index field width in the command struct (enough for the largest tap count)
  localparam int IDX_W = 6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_Y,
    OP_ERR,
    OP_G,
    OP_D,
    OP_DIV,
    OP_W,
    OP_PROW,
    OP_P,
    OP_DONE
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_Y,
    ST_ERR,
    ST_G,
    ST_D,
    ST_DEN,
    ST_DIV,
    ST_W,
    ST_PROW,
    ST_P,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       ph;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             first;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_busy;
    logic out_busy;
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LAMBDA     = 2'd0;
  localparam logic [1:0] CFG_INV_LAMBDA = 2'd1;
  localparam logic [1:0] CFG_P_DIAG     = 2'd2;

  // Register reset values
  localparam logic [15:0] LAMBDA_RST     = 16'd32440;
  localparam logic [30:0] INV_LAMBDA_RST = 31'd16946684;
  localparam logic [30:0] P_DIAG_RST     = 31'd1677721600;

endpackage

FILE: design/rls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/rls_div.sv
// Bit-serial restoring divider: (num * 2^(NW-32)) / den, truncated toward zero,
// returned as magnitude and sign. One quotient bit per cycle. No dependencies.
module rls_div #(
  parameter int NW = 56
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo,
  output logic               neg
);

  localparam int CW = $clog2(NW + 1);

  logic [32:0]   rem;
  logic [31:0]   dv;
  logic [CW-1:0] cnt;
  logic [31:0]   num_mag;
  logic [31:0]   den_mag;
  logic [32:0]   rem_sh;
  logic          ge;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);
  assign rem_sh  = {rem[31:0], quo[NW-1]};
  assign ge      = rem_sh >= {1'b0, dv};

  // Control: stay busy from start until all NW quotient bits are done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract if it fits
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {num_mag, {(NW-32){1'b0}}};
      rem <= '0;
      dv  <= den_mag;
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      if (ge) begin
        rem <= rem_sh - {1'b0, dv};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/rls_datapath.sv
// Datapath of the adaptive filter: weights, history, gains, covariance RAM,
// the shared multiplier and accumulator, the divider and the output register.
// Depends on rls_pkg, rls_ram and rls_div.
module rls_datapath import rls_pkg::*; #(
  parameter int TAPS      = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic signed [15:0] sample_in,
  input  logic signed [15:0] desired_in,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_sample,
  output logic               out_flag
);

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int AW = (TAPS > 1) ? $clog2(TAPS * TAPS) : 1;
  localparam int NW = 32 + FRAC_BITS;
  localparam int UP = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
  localparam int DN = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
  localparam logic signed [63:0] UP_HALF = (UP > 0) ? (64'sd1 <<< (UP - 1)) : 64'sd0;
  localparam logic signed [63:0] DN_HALF = (DN > 0) ? (64'sd1 <<< (DN - 1)) : 64'sd0;
  localparam logic signed [63:0] Q_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [IW-1:0]      LAST    = IW'(TAPS - 1);

  // Q1.15 to internal format, rounding when shifting down
  function automatic logic signed [63:0] from_q15(input logic signed [16:0] s);
    logic signed [63:0] v;
    v = 64'(s);
    return ((v <<< UP) + DN_HALF) >>> DN;
  endfunction

  // Internal format to Q1.15, rounding when shifting down
  function automatic logic signed [63:0] to_q15(input logic signed [31:0] s);
    logic signed [63:0] v;
    v = 64'(s);
    return ((v <<< DN) + UP_HALF) >>> UP;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // State and registers
  logic signed [31:0] w    [TAPS];
  logic signed [15:0] hist [TAPS];
  logic signed [31:0] g    [TAPS];
  logic [IW-1:0]      pos;
  logic [15:0]        lam;
  logic [30:0]        invl;
  logic [30:0]        pdiag;
  logic signed [63:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] den;
  logic signed [31:0] err;
  logic signed [31:0] gi;
  logic signed [31:0] dq;
  logic signed [15:0] yo;
  logic               flag;

  // Combinational values
  logic [IW-1:0]      ci;
  logic [IW-1:0]      cj;
  logic [IW-1:0]      xk;
  logic [IW:0]        hsum;
  logic [IW:0]        hadj;
  logic [IW-1:0]      hidx;
  logic signed [63:0] xfull;
  logic signed [31:0] xval;
  logic signed [31:0] g_rd;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] qm;
  logic signed [63:0] lam_qf;
  logic signed [63:0] acc_base;
  logic signed [63:0] acc_sum;
  logic signed [31:0] ram_q_s;
  logic [31:0]        ram_q;
  logic signed [31:0] kk;
  logic signed [63:0] dfull;
  logic signed [31:0] dval;
  logic signed [31:0] pnew;
  logic signed [31:0] y_s;
  logic signed [63:0] yq;
  logic signed [15:0] yo_s;
  logic               yo_ovf;
  logic signed [63:0] e_full;
  logic signed [63:0] wsum;
  logic signed [63:0] q64;
  logic signed [63:0] dres;
  logic               set_flag;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [31:0]        ram_wdata;
  logic               div_start;
  logic               div_busy;
  logic [NW-1:0]      div_quo;
  logic               div_neg;
  logic               den_is_zero;

  assign ci = cmd.i[IW-1:0];
  assign cj = cmd.j[IW-1:0];

  // Sample age k reads history at (pos - k) mod TAPS
  assign xk    = (cmd.op == OP_G) ? cj : ci;
  assign hsum  = {1'b0, pos} + (IW+1)'(TAPS) - {1'b0, xk};
  assign hadj  = (hsum >= (IW+1)'(TAPS)) ? hsum - (IW+1)'(TAPS) : hsum;
  assign hidx  = hadj[IW-1:0];
  assign xfull = from_q15({hist[hidx][15], hist[hidx]});
  assign xval  = xfull[31:0];

  // One gain read port, column index only in the covariance update
  assign g_rd = g[(cmd.op == OP_P) ? cj : ci];

  assign ram_q_s = $signed(ram_q);
  assign qm      = (prod + Q_HALF) >>> FRAC_BITS;
  assign lam_qf  = from_q15({1'b0, lam});

  always_comb begin
    if (cmd.first) begin
      acc_base = (cmd.op == OP_D) ? lam_qf : 64'sd0;
    end else begin
      acc_base = acc;
    end
  end
  assign acc_sum = acc_base + qm;

  // Covariance update terms
  assign kk    = sat32(qm);
  assign dfull = 64'(ram_q_s) - qm;
  assign dval  = sat32(dfull);
  assign pnew  = sat32(qm);

  // Output and error
  assign y_s    = sat32(acc);
  assign yq     = to_q15(y_s);
  assign yo_ovf = (yq > 64'sd32767) || (yq < -64'sd32768);
  always_comb begin
    if (yq > 64'sd32767) begin
      yo_s = 16'sh7FFF;
    end else if (yq < -64'sd32768) begin
      yo_s = 16'sh8000;
    end else begin
      yo_s = yq[15:0];
    end
  end
  assign e_full = 64'(dq) - 64'(y_s);

  assign wsum = 64'(w[ci]) + qm;

  // Signed quotient from the divider
  assign q64  = $signed(64'(div_quo));
  assign dres = div_neg ? -q64 : q64;

  assign den_is_zero = (sat32(acc_sum) == 32'sd0);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_Y: begin
        mul_a = w[ci];
        mul_b = xval;
      end
      OP_G: begin
        mul_a = ram_q_s;
        mul_b = xval;
      end
      OP_D: begin
        mul_a = xval;
        mul_b = g_rd;
      end
      OP_W: begin
        mul_a = g_rd;
        mul_b = err;
      end
      OP_P: begin
        case (cmd.ph)
          2'd0: begin
            mul_a = gi;
            mul_b = g_rd;
          end
          2'd1: begin
            mul_a = kk;
            mul_b = den;
          end
          2'd2: begin
            mul_a = dval;
            mul_b = $signed({1'b0, invl});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Collect saturation events
  always_comb begin
    set_flag = 1'b0;
    case (cmd.op)
      OP_ERR: set_flag = ovf32(acc) || yo_ovf || ovf32(e_full);
      OP_G:   set_flag = (cmd.ph == 2'd2) && cmd.last && ovf32(acc_sum);
      OP_D:   set_flag = (cmd.ph == 2'd1) && cmd.last && (ovf32(acc_sum) || den_is_zero);
      OP_DIV: set_flag = (cmd.ph == 2'd2) && ovf32(dres);
      OP_W:   set_flag = (cmd.ph == 2'd1) && ovf32(wsum);
      OP_P: begin
        case (cmd.ph)
          2'd1:    set_flag = ovf32(qm);
          2'd2:    set_flag = ovf32(dfull);
          2'd3:    set_flag = ovf32(qm);
          default: set_flag = 1'b0;
        endcase
      end
      default: set_flag = 1'b0;
    endcase
  end

  // Covariance memory port
  assign ram_addr  = AW'(ci) * AW'(TAPS) + AW'(cj);
  assign ram_we    = (cmd.op == OP_CLEAR) || ((cmd.op == OP_P) && (cmd.ph == 2'd3));
  assign ram_wdata = (cmd.op == OP_CLEAR) ? ((ci == cj) ? {1'b0, pdiag} : 32'd0)
                                          : 32'(pnew);

  rls_ram #(
    .WIDTH(32),
    .DEPTH(TAPS * TAPS)
  ) u_pmem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .raddr(ram_addr),
    .rdata(ram_q)
  );

  assign div_start = (cmd.op == OP_DIV) && (cmd.ph == 2'd0);

  rls_div #(
    .NW(NW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (g_rd),
    .den  (den),
    .busy (div_busy),
    .quo  (div_quo),
    .neg  (div_neg)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lam   <= LAMBDA_RST;
      invl  <= INV_LAMBDA_RST;
      pdiag <= P_DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAMBDA:     lam   <= cfg_data[15:0];
        CFG_INV_LAMBDA: invl  <= cfg_data;
        CFG_P_DIAG:     pdiag <= cfg_data;
        default: ;
      endcase
    end
  end

  // Write position and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) begin
        pos <= '0;
      end else if (cmd.op == OP_DONE) begin
        pos <= (pos == LAST) ? '0 : pos + IW'(1);
      end
      if (cmd.op == OP_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (cmd.op == OP_LOAD) begin
      flag <= 1'b0;
    end else if (set_flag) begin
      flag <= 1'b1;
    end
    case (cmd.op)
      OP_CLEAR: begin
        for (int k = 0; k < TAPS; k++) begin
          w[k]    <= '0;
          hist[k] <= '0;
        end
      end
      OP_LOAD: begin
        hist[pos] <= sample_in;
        dq        <= 32'(from_q15({desired_in[15], desired_in}));
      end
      OP_Y: begin
        if (cmd.ph == 2'd1) begin
          acc <= acc_sum;
        end
      end
      OP_ERR: begin
        yo  <= yo_s;
        err <= sat32(e_full);
      end
      OP_G: begin
        if (cmd.ph == 2'd2) begin
          acc <= acc_sum;
          if (cmd.last) begin
            g[ci] <= sat32(acc_sum);
          end
        end
      end
      OP_D: begin
        if (cmd.ph == 2'd1) begin
          acc <= acc_sum;
          if (cmd.last) begin
            den <= sat32(acc_sum);
            if (den_is_zero) begin
              for (int k = 0; k < TAPS; k++) begin
                g[k] <= '0;
              end
            end
          end
        end
      end
      OP_DIV: begin
        if (cmd.ph == 2'd2) begin
          g[ci] <= sat32(dres);
        end
      end
      OP_W: begin
        if (cmd.ph == 2'd1) begin
          w[ci] <= sat32(wsum);
        end
      end
      OP_PROW: begin
        gi <= g_rd;
      end
      OP_DONE: begin
        out_sample <= yo;
        out_flag   <= flag;
      end
      default: ;
    endcase
  end

  assign status.den_zero = (den == 32'sd0);
  assign status.div_busy = div_busy;
  assign status.out_busy = out_valid & ~out_ready;

endmodule

FILE: design/rls_ctrl.sv
// Controller of the adaptive filter: sequences the clearing pass and the
// per-sample passes over taps and covariance. Depends on rls_pkg.
module rls_ctrl import rls_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(TAPS - 1);

  state_t        state, state_next;
  logic [IW-1:0] ci, ci_next;
  logic [IW-1:0] cj, cj_next;
  logic [1:0]    ph, ph_next;
  logic          i_last;
  logic          j_last;
  logic [IW-1:0] inner;

  assign i_last = (ci == LAST);
  assign j_last = (cj == LAST);

  // Hold state; clearing pass runs after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ci    <= '0;
      cj    <= '0;
      ph    <= '0;
    end else begin
      state <= state_next;
      ci    <= ci_next;
      cj    <= cj_next;
      ph    <= ph_next;
    end
  end

  // Next state and loop counters
  always_comb begin
    state_next = state;
    ci_next    = ci;
    cj_next    = cj;
    ph_next    = ph;
    case (state)
      ST_CLEAR: begin
        if (j_last) begin
          cj_next = '0;
          if (i_last) begin
            ci_next    = '0;
            state_next = ST_IDLE;
          end else begin
            ci_next = ci + IW'(1);
          end
        end else begin
          cj_next = cj + IW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = in_kind ? ST_CLEAR : ST_Y;
        end
      end
      ST_Y, ST_D, ST_W: begin
        if (ph == 2'd0) begin
          ph_next = 2'd1;
        end else begin
          ph_next = 2'd0;
          if (i_last) begin
            ci_next = '0;
            case (state)
              ST_Y:    state_next = ST_ERR;
              ST_D:    state_next = ST_DEN;
              default: state_next = ST_PROW;
            endcase
          end else begin
            ci_next = ci + IW'(1);
          end
        end
      end
      ST_ERR: state_next = ST_G;
      ST_G: begin
        if (ph != 2'd2) begin
          ph_next = ph + 2'd1;
        end else begin
          ph_next = 2'd0;
          if (j_last) begin
            cj_next = '0;
            if (i_last) begin
              ci_next    = '0;
              state_next = ST_D;
            end else begin
              ci_next = ci + IW'(1);
            end
          end else begin
            cj_next = cj + IW'(1);
          end
        end
      end
      ST_DEN: state_next = status.den_zero ? ST_PROW : ST_DIV;
      ST_DIV: begin
        case (ph)
          2'd0: ph_next = 2'd1;
          2'd1: begin
            if (!status.div_busy) begin
              ph_next = 2'd2;
            end
          end
          default: begin
            ph_next = 2'd0;
            if (i_last) begin
              ci_next    = '0;
              state_next = ST_W;
            end else begin
              ci_next = ci + IW'(1);
            end
          end
        endcase
      end
      ST_PROW: state_next = ST_P;
      ST_P: begin
        if (ph != 2'd3) begin
          ph_next = ph + 2'd1;
        end else begin
          ph_next = 2'd0;
          if (j_last) begin
            cj_next = '0;
            if (i_last) begin
              ci_next    = '0;
              state_next = ST_DONE;
            end else begin
              ci_next    = ci + IW'(1);
              state_next = ST_PROW;
            end
          end else begin
            cj_next = cj + IW'(1);
          end
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign inner = ((state == ST_G) || (state == ST_P) || (state == ST_CLEAR)) ? cj : ci;

  // Commands to the datapath
  always_comb begin
    cmd       = '0;
    cmd.ph    = ph;
    cmd.i     = IDX_W'(ci);
    cmd.j     = IDX_W'(cj);
    cmd.first = (inner == '0);
    cmd.last  = (inner == LAST);
    in_ready  = (state == ST_IDLE);
    case (state)
      ST_CLEAR: cmd.op = OP_CLEAR;
      ST_IDLE:  cmd.op = (in_valid && !in_kind) ? OP_LOAD : OP_NONE;
      ST_Y:     cmd.op = OP_Y;
      ST_ERR:   cmd.op = OP_ERR;
      ST_G:     cmd.op = OP_G;
      ST_D:     cmd.op = OP_D;
      ST_DIV:   cmd.op = OP_DIV;
      ST_W:     cmd.op = OP_W;
      ST_PROW:  cmd.op = OP_PROW;
      ST_P:     cmd.op = OP_P;
      ST_DONE:  cmd.op = status.out_busy ? OP_NONE : OP_DONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

FILE: design/rls_adaptive_filter.sv
// Top level of the recursive least squares adaptive FIR filter.
// Depends on rls_pkg, rls_ctrl and rls_datapath.
//
// For each sample beat a single shared 32x32 multiplier walks the covariance
// twice, once for the gain and once for the update, and a bit-serial divider
// produces each gain element unless the denominator is zero. A reinitialize
// beat, and reset, run a clearing pass through the covariance memory with tready
// low; configuration writes are taken at any time. The input takes a new beat
// only when the previous one is done; a finished result waits in the output
// register while the next beat is accepted.
module rls_adaptive_filter import rls_pkg::*; #(
  parameter int TAPS      = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // input_sample [15:0], desired_sample [31:16]
  input  logic        s_axis_tuser,   // kind [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // filter_output [15:0]
  output logic        m_axis_tuser,   // saturated [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  cmd_t               cmd;
  status_t            status;
  logic signed [15:0] out_sample;

  assign cfg_ready = 1'b1;

  rls_ctrl #(
    .TAPS(TAPS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_kind (s_axis_tuser),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  rls_datapath #(
    .TAPS     (TAPS),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in ($signed(s_axis_tdata[15:0])),
    .desired_in($signed(s_axis_tdata[31:16])),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_sample(out_sample),
    .out_flag  (m_axis_tuser)
  );

  assign m_axis_tdata = out_sample;

endmodule

FILE: design/rls_checker.sv
// Port-level checks of the adaptive filter, bound to the top level.
// Depends on rls_adaptive_filter_assert.svh.
`include "rls_adaptive_filter_assert.svh"

module rls_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A taken beat keeps the input closed while it is worked
  `RLS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input beat taken while busy")

  // A new result appears only at the end of the work on a beat
  `RLS_ASSERT_NOW(a_result_at_end, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without finished work")

  // Hold a stalled result beat
  `RLS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

endmodule

bind rls_adaptive_filter rls_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
